// ===== rtl/core/napt_pkg.sv =====
// Shared types and constants for the NAPT port translation table.
// Used by the entry cell and by the top level; depends on nothing else.
package napt_pkg;

    // Width of an entry index carried along the cell row.
    localparam int IDX_W = 8;

    // Range of external ports handed out to new mappings.
    localparam int unsigned PORT_FIRST = 32768;
    localparam int unsigned PORT_END   = 61000;

    // IP protocol numbers that get translated.
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    // Result status codes.
    localparam logic [2:0] ST_TRANSLATED = 3'd0;
    localparam logic [2:0] ST_BYPASS     = 3'd1;
    localparam logic [2:0] ST_NOT_TCPUDP = 3'd2;
    localparam logic [2:0] ST_NO_ENTRY   = 3'd3;
    localparam logic [2:0] ST_TABLE_FULL = 3'd4;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_WAN_ADDRESS,
        REG_LAN_SUBNET,
        REG_LAN_NETMASK,
        REG_LAN_CHECK_ENABLE,
        REG_TIMEOUT_MS
    } reg_idx_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_CREATE,
        S_WRITE,
        S_FINISH
    } state_t;

    // Search key, held steady while one beat is worked on.
    typedef struct packed {
        logic        from_wan;
        logic        tbl;
        logic [31:0] src_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] now_ms;
        logic [31:0] timeout_ms;
    } key_t;

    // Probe that walks along the row of cells, one cell per cycle.
    typedef struct packed {
        logic             active;
        logic             create;
        logic             hit;
        logic [31:0]      hit_addr;
        logic [15:0]      hit_port;
        logic [15:0]      hit_ext;
        logic             free_found;
        logic [IDX_W-1:0] free_idx;
    } probe_t;

    // Write of a new mapping, broadcast to all cells.
    typedef struct packed {
        logic             en;
        logic             tbl;
        logic [IDX_W-1:0] idx;
        logic [31:0]      inner_addr;
        logic [15:0]      inner_port;
        logic [15:0]      ext_port;
        logic [31:0]      now_ms;
    } wr_t;

endpackage

// ===== rtl/core/napt_cell.sv =====
// One entry slot of the mapping tables, holding the TCP and the UDP entry.
// Depends on napt_pkg for the key, probe and write types.
module napt_cell
    import napt_pkg::*;
#(
    parameter int BITMAP_W = 33
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [IDX_W-1:0]    cell_idx,
    input  key_t                key,
    input  wr_t                 wr,
    input  probe_t              probe_in,
    input  logic [BITMAP_W-1:0] bitmap_in,
    output probe_t              probe_out,
    output logic [BITMAP_W-1:0] bitmap_out
);

    logic [1:0]  valid_reg;
    logic [31:0] inner_addr_reg [2];
    logic [15:0] inner_port_reg [2];
    logic [15:0] ext_reg [2];
    logic [31:0] last_reg [2];

    probe_t              probe_reg;
    probe_t              probe_next;
    logic [BITMAP_W-1:0] bitmap_reg;
    logic [BITMAP_W-1:0] bitmap_next;

    logic        v;
    logic [31:0] age;
    logic        expired;
    logic        live;
    logic        match;
    logic        clear;
    logic        touch;
    logic        wr_here;

    // Ageing, matching, free-slot and used-port tracking for the visited entry.
    always_comb
    begin
        v       = valid_reg[key.tbl];
        age     = key.now_ms - last_reg[key.tbl];
        expired = v && (age >= key.timeout_ms);
        live    = v && !expired;
        if (key.from_wan)
        begin
            match = (ext_reg[key.tbl] == key.dst_port);
        end
        else
        begin
            match = (inner_addr_reg[key.tbl] == key.src_addr) &&
                    (inner_port_reg[key.tbl] == key.src_port);
        end

        probe_next  = probe_in;
        bitmap_next = bitmap_in;
        clear       = 1'b0;
        touch       = 1'b0;

        if (probe_in.active && (probe_in.create || !probe_in.hit))
        begin
            clear = expired;
        end

        if (probe_in.active && !probe_in.create && !probe_in.hit && live && match)
        begin
            probe_next.hit      = 1'b1;
            probe_next.hit_addr = inner_addr_reg[key.tbl];
            probe_next.hit_port = inner_port_reg[key.tbl];
            probe_next.hit_ext  = ext_reg[key.tbl];
            touch               = 1'b1;
        end

        if (probe_in.active && probe_in.create)
        begin
            if (!live)
            begin
                probe_next.free_found = 1'b1;
                probe_next.free_idx   = cell_idx;
            end
            for (int j = 0; j < BITMAP_W; j++)
            begin
                if (ext_reg[key.tbl] == 16'(PORT_FIRST + j))
                begin
                    bitmap_next[j] = 1'b1;
                end
            end
        end
    end

    assign wr_here = wr.en && (wr.idx == cell_idx);

    // Valid bits, external ports, the probe stage and its port bitmap are reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            ext_reg[0] <= '0;
            ext_reg[1] <= '0;
            probe_reg  <= '0;
            bitmap_reg <= '0;
        end
        else
        begin
            probe_reg  <= probe_next;
            bitmap_reg <= bitmap_next;
            if (wr_here)
            begin
                valid_reg[wr.tbl] <= 1'b1;
                ext_reg[wr.tbl]   <= wr.ext_port;
            end
            else if (clear)
            begin
                valid_reg[key.tbl] <= 1'b0;
            end
        end
    end

    // Entry contents without reset.
    always_ff @(posedge clk)
    begin
        if (wr_here)
        begin
            inner_addr_reg[wr.tbl] <= wr.inner_addr;
            inner_port_reg[wr.tbl] <= wr.inner_port;
            last_reg[wr.tbl]       <= wr.now_ms;
        end
        else if (touch)
        begin
            last_reg[key.tbl] <= key.now_ms;
        end
    end

    assign probe_out  = probe_reg;
    assign bitmap_out = bitmap_reg;

endmodule

// ===== rtl/core/napt_port_translation_table.sv =====
// NAPT port translation table: one packet tuple in, one translated tuple out.
// Bypass and non-TCP/UDP beats go straight to the finish state; a lookup waits for the
// probe to walk the row of entry cells, and a LAN miss walks it once more to create a
// new mapping; one beat is worked on at a time.
// The next beat is taken in the cycle after the result is loaded, even while it waits.
// Reset (rst_n, asynchronous) clears all mappings and restores the registers.
module napt_port_translation_table
    import napt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        from_wan,
    input  logic [7:0]  protocol,
    input  logic [31:0] src_addr,
    input  logic [31:0] dst_addr,
    input  logic [15:0] src_port,
    input  logic [15:0] dst_port,
    input  logic [31:0] now_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [31:0] out_src_addr,
    output logic [31:0] out_dst_addr,
    output logic [15:0] out_src_port,
    output logic [15:0] out_dst_port
);

    localparam int BITMAP_W = TABLE_ENTRIES + 1;

    // Configuration registers.
    logic [31:0] wan_address_reg;
    logic [31:0] lan_subnet_reg;
    logic [31:0] lan_netmask_reg;
    logic        lan_check_enable_reg;
    logic [31:0] timeout_ms_reg;
    reg_idx_t    reg_idx;

    state_t state_reg;
    state_t state_next;

    key_t        key_reg;
    logic        launch_reg;
    logic        launch_next;
    logic [2:0]  res_status_reg;
    logic [31:0] res_sa_reg;
    logic [31:0] res_da_reg;
    logic [15:0] res_sp_reg;
    logic [15:0] res_dp_reg;
    logic [IDX_W-1:0] slot_reg;
    logic [15:0] port_reg;
    logic [15:0] pick_port;

    logic        out_valid_reg;
    logic [2:0]  out_status_reg;
    logic [31:0] out_sa_reg;
    logic [31:0] out_da_reg;
    logic [15:0] out_sp_reg;
    logic [15:0] out_dp_reg;

    logic        accept;
    logic        bypass;
    logic        is_tcp_udp;
    logic        early;
    logic        out_free;
    logic        load_out;
    logic        do_write;

    probe_t              chain [TABLE_ENTRIES+1];
    logic [BITMAP_W-1:0] bm_chain [TABLE_ENTRIES+1];
    probe_t              tail;
    wr_t                 wr;

    // Register access.
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[4:2]);

    always_comb
    begin
        unique case (reg_idx)
            REG_WAN_ADDRESS:      prdata = wan_address_reg;
            REG_LAN_SUBNET:       prdata = lan_subnet_reg;
            REG_LAN_NETMASK:      prdata = lan_netmask_reg;
            REG_LAN_CHECK_ENABLE: prdata = {31'd0, lan_check_enable_reg};
            REG_TIMEOUT_MS:       prdata = timeout_ms_reg;
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wan_address_reg      <= '0;
            lan_subnet_reg       <= '0;
            lan_netmask_reg      <= '0;
            lan_check_enable_reg <= 1'b0;
            timeout_ms_reg       <= 32'd60000;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (reg_idx)
                REG_WAN_ADDRESS:      wan_address_reg      <= pwdata;
                REG_LAN_SUBNET:       lan_subnet_reg       <= pwdata;
                REG_LAN_NETMASK:      lan_netmask_reg      <= pwdata;
                REG_LAN_CHECK_ENABLE: lan_check_enable_reg <= pwdata[0];
                REG_TIMEOUT_MS:       timeout_ms_reg       <= pwdata;
                default:              ;
            endcase
        end
    end

    // Bypass and protocol tests on the incoming beat.
    always_comb
    begin
        if (from_wan)
        begin
            bypass = (dst_addr != wan_address_reg);
        end
        else
        begin
            bypass = lan_check_enable_reg && ((dst_addr & lan_netmask_reg) == lan_subnet_reg);
        end
        is_tcp_udp = (protocol == PROTO_TCP) || (protocol == PROTO_UDP);
        early      = bypass || !is_tcp_udp;
    end

    // Row of entry cells; the probe enters at cell 0 and leaves at the tail.
    assign chain[0]    = '{active: launch_reg, create: (state_reg == S_CREATE), default: '0};
    assign bm_chain[0] = '0;
    assign tail        = chain[TABLE_ENTRIES];

    always_comb
    begin
        wr.en         = do_write;
        wr.tbl        = key_reg.tbl;
        wr.idx        = slot_reg;
        wr.inner_addr = key_reg.src_addr;
        wr.inner_port = key_reg.src_port;
        wr.ext_port   = port_reg;
        wr.now_ms     = key_reg.now_ms;
    end

    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        napt_cell #(
            .BITMAP_W (BITMAP_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_idx   (IDX_W'(i)),
            .key        (key_reg),
            .wr         (wr),
            .probe_in   (chain[i]),
            .bitmap_in  (bm_chain[i]),
            .probe_out  (chain[i+1]),
            .bitmap_out (bm_chain[i+1])
        );
    end

    // Lowest port in the candidate range that no entry holds.
    always_comb
    begin
        pick_port = 16'(PORT_FIRST);
        for (int j = BITMAP_W - 1; j >= 0; j--)
        begin
            if (!bm_chain[TABLE_ENTRIES][j])
            begin
                pick_port = 16'(PORT_FIRST + j);
            end
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = early ? S_FINISH : S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                if (tail.active)
                begin
                    state_next = (tail.hit || key_reg.from_wan) ? S_FINISH : S_CREATE;
                end
            end
            S_CREATE:
            begin
                if (tail.active)
                begin
                    state_next = tail.free_found ? S_WRITE : S_FINISH;
                end
            end
            S_WRITE:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        out_free    = !out_valid_reg || !out_stall;
        in_stall    = (state_reg != S_IDLE);
        accept      = in_valid && (state_reg == S_IDLE);
        launch_next = (accept && !early) ||
                      ((state_reg == S_LOOKUP) && tail.active && !tail.hit && !key_reg.from_wan);
        do_write    = (state_reg == S_WRITE);
        load_out    = (state_reg == S_FINISH) && out_free;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            launch_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= launch_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working tuple and result fields.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg.from_wan   <= from_wan;
            key_reg.tbl        <= (protocol == PROTO_UDP);
            key_reg.src_addr   <= src_addr;
            key_reg.src_port   <= src_port;
            key_reg.dst_port   <= dst_port;
            key_reg.now_ms     <= now_ms;
            key_reg.timeout_ms <= timeout_ms_reg;
            res_sa_reg         <= src_addr;
            res_da_reg         <= dst_addr;
            res_sp_reg         <= src_port;
            res_dp_reg         <= dst_port;
            res_status_reg     <= bypass ? ST_BYPASS : ST_NOT_TCPUDP;
        end
        else if ((state_reg == S_LOOKUP) && tail.active)
        begin
            if (tail.hit)
            begin
                res_status_reg <= ST_TRANSLATED;
                if (key_reg.from_wan)
                begin
                    res_da_reg <= tail.hit_addr;
                    res_dp_reg <= tail.hit_port;
                end
                else
                begin
                    res_sa_reg <= wan_address_reg;
                    res_sp_reg <= tail.hit_ext;
                end
            end
            else
            begin
                res_status_reg <= ST_NO_ENTRY;
            end
        end
        else if ((state_reg == S_CREATE) && tail.active)
        begin
            if (tail.free_found)
            begin
                res_status_reg <= ST_TRANSLATED;
                res_sa_reg     <= wan_address_reg;
                res_sp_reg     <= pick_port;
                slot_reg       <= tail.free_idx;
                port_reg       <= pick_port;
            end
            else
            begin
                res_status_reg <= ST_TABLE_FULL;
            end
        end

        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_sa_reg     <= res_sa_reg;
            out_da_reg     <= res_da_reg;
            out_sp_reg     <= res_sp_reg;
            out_dp_reg     <= res_dp_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign out_src_addr = out_sa_reg;
    assign out_dst_addr = out_da_reg;
    assign out_src_port = out_sp_reg;
    assign out_dst_port = out_dp_reg;

`ifndef SYNTHESIS
    // The probe only leaves the row while a lookup or creation pass is running.
    a_tail_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
        tail.active |-> (state_reg == S_LOOKUP) || (state_reg == S_CREATE))
        else $error("probe left the cell row outside a pass");

    // A new mapping always gets a port inside the allocation range.
    a_port_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |->
            (port_reg >= 16'(PORT_FIRST)) && (32'(port_reg) < PORT_END))
        else $error("allocated port out of range");

    // A write of a new mapping is followed by the result being offered.
    a_write_then_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |=> (state_reg == S_FINISH))
        else $error("mapping write not followed by finish");

    // Status codes beyond table full are never produced.
    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status <= ST_TABLE_FULL))
        else $error("illegal status code");
`endif

endmodule
